// File: design/aprb_pkg.sv
// Package for the aging point ring buffer.
// Holds request and result structs, operation codes and register indexes.
// No dependencies.
`default_nettype none

package aprb_pkg;

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_POINTS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIFETIME   = 4'd1;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_AGE    = 3'd1;
  localparam logic [2:0] OP_EXPIRE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [6:0]  MAX_POINTS_RESET = 7'd64;
  localparam logic [31:0] LIFETIME_RESET   = 32'd65536;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        delta_time;
    logic [5:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [31:0]        point_age;
    logic               index_valid;
    logic [6:0]         point_count;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  max_points;
    logic [31:0] lifetime;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/aprb_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module aprb_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/aprb_ctrl.sv
// Sequencer of the aging point ring buffer: head, count, walks and result register.
// Depends on aprb_pkg; drives the point and age RAMs.
`default_nettype none

module aprb_ctrl import aprb_pkg::*; #(
  parameter int Capacity = 64,
  parameter int Aw = 6,
  parameter int Cw = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_item_t      in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output out_item_t          out_data,
  output logic               pt_we,
  output logic [Aw-1:0]      pt_waddr,
  output logic [63:0]        pt_wdata,
  output logic [Aw-1:0]      pt_raddr,
  input  wire logic [63:0]   pt_rdata,
  output logic               age_we,
  output logic [Aw-1:0]      age_waddr,
  output logic [31:0]        age_wdata,
  output logic [Aw-1:0]      age_raddr,
  input  wire logic [31:0]   age_rdata
);

  localparam int Sw = Cw + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_EXP_RD,
    S_EXP_CHK,
    S_READ,
    S_FINISH
  } state_t;

  state_t             state, state_next;
  logic [Aw-1:0]      head, head_next;
  logic [Cw-1:0]      count, count_next;
  logic [Cw-1:0]      idx, idx_next;
  logic               pend, pend_next;
  logic [Aw-1:0]      pend_slot, pend_slot_next;
  logic [31:0]        dt, dt_next;
  logic signed [31:0] res_x, res_x_next;
  logic signed [31:0] res_y, res_y_next;
  logic [31:0]        res_age, res_age_next;
  logic               res_valid, res_valid_next;
  logic               out_valid_next;
  out_item_t          out_data_next;

  logic [Cw-1:0]      lim;
  logic [Aw-1:0]      slot;
  logic [Aw-1:0]      head_adv;
  logic [32:0]        age_sum;

  function automatic logic [Aw-1:0] wrap(input logic [Sw-1:0] s);
    logic [Sw-1:0] r;
    r = s;
    if (s >= Sw'(Capacity)) begin
      r = s - Sw'(Capacity);
    end
    return r[Aw-1:0];
  endfunction

  assign in_stall = (state != S_IDLE);

  always_comb begin
    if (cfg.max_points == 7'd0) begin
      lim = Cw'(1);
    end else if (cfg.max_points > Capacity) begin
      lim = Cw'(Capacity);
    end else begin
      lim = Cw'(cfg.max_points);
    end
  end

  assign age_sum = {1'b0, age_rdata} + {1'b0, dt};

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    idx_next       = idx;
    pend_next      = pend;
    pend_slot_next = pend_slot;
    dt_next        = dt;
    res_x_next     = res_x;
    res_y_next     = res_y;
    res_age_next   = res_age;
    res_valid_next = res_valid;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    pt_we          = 1'b0;
    pt_waddr       = '0;
    pt_wdata       = '0;
    pt_raddr       = '0;
    age_we         = 1'b0;
    age_waddr      = '0;
    age_wdata      = '0;
    age_raddr      = '0;
    slot           = '0;
    head_adv       = '0;

    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dt_next        = in_data.delta_time;
          res_x_next     = '0;
          res_y_next     = '0;
          res_age_next   = '0;
          res_valid_next = 1'b0;
          state_next     = S_FINISH;
          case (in_data.operation)
            OP_ADD: begin
              if (count < lim) begin
                slot       = wrap(Sw'(head) + Sw'(count));
                count_next = count + Cw'(1);
              end else begin
                head_adv  = wrap(Sw'(head) + Sw'(1));
                head_next = head_adv;
                slot      = wrap(Sw'(head_adv) + Sw'(lim) - Sw'(1));
              end
              pt_we     = 1'b1;
              pt_waddr  = slot;
              pt_wdata  = {in_data.pos_x, in_data.pos_y};
              age_we    = 1'b1;
              age_waddr = slot;
              age_wdata = '0;
            end
            OP_AGE: begin
              idx_next   = '0;
              pend_next  = 1'b0;
              state_next = S_AGE;
            end
            OP_EXPIRE: begin
              state_next = S_EXP_RD;
            end
            OP_CLEAR: begin
              head_next  = '0;
              count_next = '0;
            end
            OP_READ: begin
              if (in_data.read_index < count) begin
                slot       = wrap(Sw'(head) + Sw'(in_data.read_index));
                pt_raddr   = slot;
                age_raddr  = slot;
                state_next = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_AGE: begin
        if (idx < count) begin
          slot           = wrap(Sw'(head) + Sw'(idx));
          age_raddr      = slot;
          idx_next       = idx + Cw'(1);
          pend_next      = 1'b1;
          pend_slot_next = slot;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          age_we    = 1'b1;
          age_waddr = pend_slot;
          age_wdata = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
        end
        if (idx == count && !pend) begin
          state_next = S_FINISH;
        end
      end
      S_EXP_RD: begin
        if (count == '0) begin
          state_next = S_FINISH;
        end else begin
          age_raddr  = head;
          state_next = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (age_rdata > cfg.lifetime) begin
          head_next  = wrap(Sw'(head) + Sw'(1));
          count_next = count - Cw'(1);
          state_next = S_EXP_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        res_x_next     = pt_rdata[63:32];
        res_y_next     = pt_rdata[31:0];
        res_age_next   = age_rdata;
        res_valid_next = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_valid_next            = 1'b1;
          out_data_next.point_x     = res_x;
          out_data_next.point_y     = res_y;
          out_data_next.point_age   = res_age;
          out_data_next.index_valid = res_valid;
          out_data_next.point_count = 7'(count);
          state_next                = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      idx       <= idx_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
    pend_slot <= pend_slot_next;
    dt        <= dt_next;
    res_x     <= res_x_next;
    res_y     <= res_y_next;
    res_age   <= res_age_next;
    res_valid <= res_valid_next;
    out_data  <= out_data_next;
  end

endmodule

`default_nettype wire

// File: design/aging_point_ring_buffer_top.sv
// Aging point ring buffer: one request at a time, result held in an output register.
// Add, clear, unknown codes and out-of-range reads go straight to the result register; a read
// first fetches the point and its age; age walks every stored point; expire drops the oldest
// point while its age exceeds the lifetime, until the store is empty.
// The next request is taken the cycle after the previous result is registered.
// Reset clears head and count and loads the configuration defaults; the point and age RAMs keep their contents.
`default_nettype none

module aging_point_ring_buffer_top import aprb_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data
);

  localparam int Aw = $clog2(CAPACITY);
  localparam int Cw = $clog2(CAPACITY + 1);

  cfg_t          cfg;
  logic          pt_we;
  logic [Aw-1:0] pt_waddr;
  logic [63:0]   pt_wdata;
  logic [Aw-1:0] pt_raddr;
  logic [63:0]   pt_rdata;
  logic          age_we;
  logic [Aw-1:0] age_waddr;
  logic [31:0]   age_wdata;
  logic [Aw-1:0] age_raddr;
  logic [31:0]   age_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_points <= MAX_POINTS_RESET;
      cfg.lifetime   <= LIFETIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_POINTS: cfg.max_points <= cfg_data[6:0];
        REG_LIFETIME:   cfg.lifetime   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  aprb_ctrl #(
    .Capacity (CAPACITY),
    .Aw       (Aw),
    .Cw       (Cw)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pt_we     (pt_we),
    .pt_waddr  (pt_waddr),
    .pt_wdata  (pt_wdata),
    .pt_raddr  (pt_raddr),
    .pt_rdata  (pt_rdata),
    .age_we    (age_we),
    .age_waddr (age_waddr),
    .age_wdata (age_wdata),
    .age_raddr (age_raddr),
    .age_rdata (age_rdata)
  );

  aprb_ram #(
    .Width (64),
    .Depth (CAPACITY)
  ) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  aprb_ram #(
    .Width (32),
    .Depth (CAPACITY)
  ) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (age_raddr),
    .rdata (age_rdata)
  );

endmodule

`default_nettype wire
